>>> hdl/ssr_pkg.sv
// ssr_pkg: types, constants and helpers shared by the substring replace block.
// Used by ssr_cell, ssr_ctrl and stream_substring_replace; depends on nothing.
package ssr_pkg;

  localparam int unsigned ByteW          = 8;
  localparam int unsigned MaxPattern     = 8;
  localparam int unsigned MaxReplacement = 8;
  localparam int unsigned FillW          = 4;   // holds 0..MaxPattern
  localparam int unsigned IdxW           = 3;   // indexes one of MaxPattern cells
  localparam int unsigned LenW           = 4;
  localparam int unsigned TotalW         = 16;
  localparam int unsigned CfgIdxW        = 4;
  localparam int unsigned CfgDataW       = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_BYTES      = 4'd0,
    REG_PATTERN_LENGTH     = 4'd1,
    REG_REPLACEMENT_BYTES  = 4'd2,
    REG_REPLACEMENT_LENGTH = 4'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_ENTRY,
    ST_REPL,
    ST_FLUSH
  } ssr_state_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_has_byte;
    logic             in_last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              out_has_byte;
    logic              out_last;
    logic [TotalW-1:0] replace_total;
  } out_item_t;

  // Window row control, broadcast from the sequencer to every cell
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IdxW-1:0]  wr_idx;
    logic [ByteW-1:0] wr_byte;
  } cell_ctl_t;

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
    logic [TotalW-1:0] r;
    r = (v == {TotalW{1'b1}}) ? v : TotalW'(v + 1'b1);
    return r;
  endfunction

endpackage

>>> hdl/ssr_cell.sv
// ssr_cell: one byte of the match window with its pattern comparators.
// Depends on ssr_pkg.
module ssr_cell
  import ssr_pkg::*;
(
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             load_i,
  input  logic [ByteW-1:0] load_byte_i,
  input  logic [ByteW-1:0] next_byte_i,
  input  logic [ByteW-1:0] pat_cur_i,
  input  logic [ByteW-1:0] pat_prev_i,
  output logic [ByteW-1:0] byte_o,
  output logic             eq_cur_o,
  output logic             eq_prev_o
);

  logic [ByteW-1:0] byte_q, byte_d;

  // load beats shift: a pop and an append can land in the same cycle
  always_comb begin
    byte_d = byte_q;
    if (load_i) begin
      byte_d = load_byte_i;
    end else if (shift_i) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o    = byte_q;
  assign eq_cur_o  = (byte_q == pat_cur_i);
  assign eq_prev_o = (byte_q == pat_prev_i);

endmodule

>>> hdl/ssr_ctrl.sv
// ssr_ctrl: item holding stage, replace sequencer, fill and tally counters,
// and the result output register. Depends on ssr_pkg.
module ssr_ctrl
  import ssr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  in_item_t                   in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output out_item_t                  out_data_o,
  input  logic [CfgDataW-1:0]        pat_bytes_i,
  input  logic [LenW-1:0]            pat_len_i,
  input  logic [CfgDataW-1:0]        rep_bytes_i,
  input  logic [LenW-1:0]            rep_len_i,
  input  logic [ByteW-1:0]           head_byte_i,
  input  logic [MaxPattern-1:0]      eq_cur_i,
  input  logic [MaxPattern-1:0]      eq_prev_i,
  output cell_ctl_t                  cell_ctl_o
);

  ssr_state_e        state_q, state_d;
  logic              item_vld_q, item_vld_d;
  in_item_t          item_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [TotalW-1:0] tally_q, tally_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              emitted_q, emitted_d;
  logic              out_vld_q, out_vld_d;
  out_item_t         out_q, out_d;

  logic              accept, done, emit, emit_ok;
  out_item_t         res;
  logic [IdxW-1:0]   plen_m1, rlen_m1, fill_idx;
  logic              new_eq, cur_match, look_match;
  logic [MaxPattern-1:0] lt_fill, look_mask;

  assign plen_m1  = IdxW'(pat_len_i - 1'b1);
  assign rlen_m1  = IdxW'(rep_len_i - 1'b1);
  assign fill_idx = fill_q[IdxW-1:0];
  assign new_eq   = (item_q.in_byte == pat_bytes_i[{plen_m1, 3'b000} +: ByteW]);

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      lt_fill[i]   = (FillW'(i) < fill_q);
      look_mask[i] = (i != 0) && (FillW'(i) < pat_len_i);
    end
  end

  // window as it stands, and as it will stand after the last drain pop
  assign cur_match  = new_eq && (&(eq_cur_i | ~lt_fill));
  assign look_match = new_eq && (&(eq_prev_i | ~look_mask));

  assign emit_ok = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    tally_d    = tally_q;
    idx_d      = idx_q;
    done       = 1'b0;
    emit       = 1'b0;
    res        = '0;
    cell_ctl_o = '{shift: 1'b0, wr_en: 1'b0, wr_idx: fill_idx, wr_byte: item_q.in_byte};

    case (state_q)
      ST_ENTRY: begin
        if (item_vld_q) begin
          if (item_q.in_has_byte) begin
            if (fill_q >= pat_len_i) begin
              // pattern shortened mid-string: drain oldest bytes first
              if (emit_ok) begin
                emit             = 1'b1;
                res.out_byte     = head_byte_i;
                res.out_has_byte = 1'b1;
                if (item_q.in_last && fill_q == pat_len_i && look_match &&
                    rep_len_i == '0) begin
                  res.out_last      = 1'b1;
                  res.replace_total = sat_inc(tally_q);
                end
                cell_ctl_o.shift = 1'b1;
                fill_d           = FillW'(fill_q - 1'b1);
              end
            end else if (FillW'(fill_q + 1'b1) != pat_len_i) begin
              cell_ctl_o.wr_en = 1'b1;
              fill_d           = FillW'(fill_q + 1'b1);
              if (item_q.in_last) begin
                state_d = ST_FLUSH;
              end else begin
                done = 1'b1;
              end
            end else if (cur_match) begin
              fill_d  = '0;
              tally_d = sat_inc(tally_q);
              if (rep_len_i != '0) begin
                state_d = ST_REPL;
                idx_d   = '0;
              end else if (item_q.in_last) begin
                state_d = ST_FLUSH;
              end else begin
                done = 1'b1;
              end
            end else if (emit_ok) begin
              emit             = 1'b1;
              res.out_byte     = (fill_q == '0) ? item_q.in_byte : head_byte_i;
              res.out_has_byte = 1'b1;
              if (item_q.in_last && fill_q == '0) begin
                res.out_last      = 1'b1;
                res.replace_total = tally_q;
              end
              if (fill_q != '0) begin
                cell_ctl_o.shift  = 1'b1;
                cell_ctl_o.wr_en  = 1'b1;
                cell_ctl_o.wr_idx = IdxW'(fill_idx - 1'b1);
              end
              if (item_q.in_last && fill_q != '0) begin
                state_d = ST_FLUSH;
              end else begin
                done = 1'b1;
              end
            end
          end else if (item_q.in_last) begin
            state_d = ST_FLUSH;
          end else begin
            done = 1'b1;
          end
        end
      end

      ST_REPL: begin
        if (emit_ok) begin
          emit             = 1'b1;
          res.out_byte     = rep_bytes_i[{idx_q, 3'b000} +: ByteW];
          res.out_has_byte = 1'b1;
          if (idx_q == rlen_m1) begin
            done = 1'b1;
            if (item_q.in_last) begin
              res.out_last      = 1'b1;
              res.replace_total = tally_q;
            end
          end else begin
            idx_d = IdxW'(idx_q + 1'b1);
          end
        end
      end

      ST_FLUSH: begin
        if (fill_q != '0) begin
          if (emit_ok) begin
            emit             = 1'b1;
            res.out_byte     = head_byte_i;
            res.out_has_byte = 1'b1;
            cell_ctl_o.shift = 1'b1;
            fill_d           = FillW'(fill_q - 1'b1);
            if (fill_q == FillW'(1)) begin
              res.out_last      = 1'b1;
              res.replace_total = tally_q;
              done              = 1'b1;
            end
          end
        end else if (emitted_q) begin
          done = 1'b1;
        end else if (emit_ok) begin
          // no byte came out of this string: send a bare end marker
          emit              = 1'b1;
          res.out_last      = 1'b1;
          res.replace_total = tally_q;
          done              = 1'b1;
        end
      end

      default: begin
        state_d = ST_ENTRY;
      end
    endcase

    if (done) begin
      state_d = ST_ENTRY;
      if (item_q.in_last) begin
        fill_d  = '0;
        tally_d = '0;
      end
    end
  end

  assign emitted_d  = done ? 1'b0 : (emitted_q || emit);
  assign in_stall_o = item_vld_q && !done;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_vld_d = accept ? 1'b1 : (done ? 1'b0 : item_vld_q);

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (emit) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_ENTRY;
      item_vld_q <= 1'b0;
      fill_q     <= '0;
      tally_q    <= '0;
      idx_q      <= '0;
      emitted_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      item_vld_q <= item_vld_d;
      fill_q     <= fill_d;
      tally_q    <= tally_d;
      idx_q      <= idx_d;
      emitted_q  <= emitted_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/stream_substring_replace.sv
// stream_substring_replace: streaming replace-all of a configured byte pattern.
// Depends on ssr_pkg, ssr_cell and ssr_ctrl.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid_i/in_stall_o   in_data_i  (in_item_t)
//   out      source     out_valid_o/out_stall_i out_data_o (out_item_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_idx_i, cfg_data_i
//
// Pace: one input transfer per clock while each byte yields at most one result.
// A byte that completes a match then sends the replacement bytes, and an end of
// string pops the bytes left in the window, the last pop carrying the end mark;
// the single result register sets the pace: one result per clock unless stalled.
// Reset: asynchronous, active low; clears the window fill, the tally and the
// registers to pattern_length 1, everything else 0. No clearing pass.
// Stalls: out_stall_i holds the result register; the held input transfer then
// waits, and in_stall_o rises until its work is done.
module stream_substring_replace
  import ssr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [CfgDataW-1:0] pat_bytes_q, rep_bytes_q;
  logic [LenW-1:0]     pat_len_q, rep_len_q;
  logic [LenW-1:0]     pat_len_eff, rep_len_eff;

  // Window row
  cell_ctl_t                          cell_ctl;
  logic [MaxPattern-1:0][ByteW-1:0]   cell_byte;
  logic [MaxPattern-1:0]              eq_cur, eq_prev;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LenW'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        REG_PATTERN_BYTES:      pat_bytes_q <= cfg_data_i;
        REG_PATTERN_LENGTH:     pat_len_q   <= cfg_data_i[LenW-1:0];
        REG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data_i;
        REG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data_i[LenW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamp lengths: a zero pattern acts as one byte, both cap at the window size
  always_comb begin
    pat_len_eff = pat_len_q;
    if (pat_len_q == '0) begin
      pat_len_eff = LenW'(1);
    end else if (pat_len_q > LenW'(MaxPattern)) begin
      pat_len_eff = LenW'(MaxPattern);
    end
    rep_len_eff = (rep_len_q > LenW'(MaxReplacement)) ? LenW'(MaxReplacement) : rep_len_q;
  end

  // Row of cells: cell 0 holds the oldest byte, a pop moves every byte one
  // cell towards it. Each cell also compares against the pattern byte one
  // place earlier, to see the window as it will be after that pop.
  for (genvar g = 0; g < MaxPattern; g++) begin : g_cell
    logic [ByteW-1:0] next_byte, pat_prev;

    if (g == MaxPattern - 1) begin : g_tail
      assign next_byte = cell_byte[g];
    end else begin : g_body
      assign next_byte = cell_byte[g+1];
    end

    if (g == 0) begin : g_head
      assign pat_prev = '0;
    end else begin : g_rest
      assign pat_prev = pat_bytes_q[(g-1)*ByteW +: ByteW];
    end

    ssr_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (cell_ctl.shift),
      .load_i      (cell_ctl.wr_en && (cell_ctl.wr_idx == IdxW'(g))),
      .load_byte_i (cell_ctl.wr_byte),
      .next_byte_i (next_byte),
      .pat_cur_i   (pat_bytes_q[g*ByteW +: ByteW]),
      .pat_prev_i  (pat_prev),
      .byte_o      (cell_byte[g]),
      .eq_cur_o    (eq_cur[g]),
      .eq_prev_o   (eq_prev[g])
    );
  end

  ssr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .pat_bytes_i (pat_bytes_q),
    .pat_len_i   (pat_len_eff),
    .rep_bytes_i (rep_bytes_q),
    .rep_len_i   (rep_len_eff),
    .head_byte_i (cell_byte[0]),
    .eq_cur_i    (eq_cur),
    .eq_prev_i   (eq_prev),
    .cell_ctl_o  (cell_ctl)
  );

  // Appends never land beyond the current pattern length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctl.wr_en |-> (FillW'(cell_ctl.wr_idx) < pat_len_eff))
    else $error("window write beyond pattern length");

  // Every pop from the row hands a byte to the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctl.shift |=> out_valid_o)
    else $error("window pop without a result transfer");

  // A result without a byte is always a bare end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.out_has_byte) |->
      (out_data_o.out_last && out_data_o.out_byte == '0))
    else $error("byteless result is not an end marker");

  // The count only travels with the final result of a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.out_last) |-> (out_data_o.replace_total == '0))
    else $error("replace count on a non-final result");

endmodule
